// ===== rtl/btsmp_pkg.sv =====
// ----------------------------------------------------------------------------
// btsmp_pkg
// Shared widths, codes and item types of the bilinear texture sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package btsmp_pkg;

  localparam int unsigned MAX_SIDE        = 256;
  localparam int unsigned MAX_TEXELS      = 65536;
  localparam int unsigned COORD_FRAC_BITS = 16;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned IDX_W     = $clog2(MAX_TEXELS);
  localparam int unsigned SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int unsigned POS_W     = $clog2(MAX_SIDE);
  localparam int unsigned COORD_W   = COORD_FRAC_BITS + 1;
  localparam int unsigned SCALED_W  = COORD_W + SIDE_W;
  localparam int unsigned ROW_W     = POS_W + SIDE_W;
  localparam int unsigned LEFT_W    = COORD_FRAC_BITS + CH_W;
  localparam int unsigned PROD_W    = 2 * COORD_FRAC_BITS + CH_W;
  localparam int unsigned OUT_SHIFT = 2 * COORD_FRAC_BITS - 16;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned OBUF_DEPTH  = 8;

  localparam logic [COORD_W-1:0] COORD_ONE = {1'b1, {COORD_FRAC_BITS{1'b0}}};

  // channel slots inside a texel or a result
  localparam int unsigned CH_BLUE  = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_RED   = 2;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEX_WIDTH  = 1'b0,
    CFG_TEX_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef logic [NUM_CH-1:0][CH_W-1:0]  texel_t;
  typedef logic [NUM_CH-1:0][OUT_W-1:0] result_t;

  // one classified item; a load uses addr00 as its write address
  typedef struct packed {
    cmd_e               cmd;
    logic [IDX_W-1:0]   addr00;
    logic [IDX_W-1:0]   addr01;
    logic [IDX_W-1:0]   addr10;
    logic [IDX_W-1:0]   addr11;
    texel_t             texel;
    logic [COORD_W-1:0] fx;
    logic [COORD_W-1:0] fy;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/bilinear_texture_sampler_core.sv =====
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_core
// Stores an RGB texture and returns bilinearly filtered samples.
// ----------------------------------------------------------------------------
// Usage:
//   cfg port  : write tex_width (index 0) or tex_height (index 1) while idle;
//               0 acts as 1, values above 256 act as 256.
//   in channel: cmd 0 loads one texel at texel_index and gives no result,
//               cmd 1 samples at (coord_u, coord_v) and gives one result.
//   out channel: out_red/out_green/out_blue in units of 2^-16.
//   Throughput is one item per cycle, loads and samples mixed freely, while
//   out_stall_i is low. An item passes 3 front stages (scale, clamp, row
//   multiply), one queue slot, the texel store read, two blend multiply
//   stages and the result buffer on its way from input to output.
//   The store keeps two copies, one per texel row, each read at two
//   addresses, so all four neighbours are read in the same cycle.
//   Reset empties the pipeline, sets a 1 x 1 texture and leaves the store
//   contents undefined; sample only texels that were loaded.
//   When out_stall_i is held, up to 8 results are buffered, then the queue
//   fills and in_stall_o rises once 8 items wait in front of the store.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_texture_sampler_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [btsmp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [btsmp_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             cmd_i,
  input  logic [btsmp_pkg::INDEX_W-1:0]    texel_index_i,
  input  logic [btsmp_pkg::CH_W-1:0]       load_red_i,
  input  logic [btsmp_pkg::CH_W-1:0]       load_green_i,
  input  logic [btsmp_pkg::CH_W-1:0]       load_blue_i,
  input  logic [btsmp_pkg::COORD_W-1:0]    coord_u_i,
  input  logic [btsmp_pkg::COORD_W-1:0]    coord_v_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [btsmp_pkg::OUT_W-1:0]      out_red_o,
  output logic [btsmp_pkg::OUT_W-1:0]      out_green_o,
  output logic [btsmp_pkg::OUT_W-1:0]      out_blue_o
);

  import btsmp_pkg::*;

  logic    op_push, q_valid, q_pop;
  op_t     op_in, op_head;
  result_t result;

  btsmp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .texel_index_i (texel_index_i),
    .load_red_i    (load_red_i),
    .load_green_i  (load_green_i),
    .load_blue_i   (load_blue_i),
    .coord_u_i     (coord_u_i),
    .coord_v_i     (coord_v_i),
    .op_push_o     (op_push),
    .op_o          (op_in),
    .op_pop_i      (q_pop)
  );

  btsmp_fifo #(
    .DEPTH  (QUEUE_DEPTH),
    .item_t (op_t)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .wdata_i (op_in),
    .valid_o (q_valid),
    .rdata_o (op_head),
    .pop_i   (q_pop)
  );

  btsmp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (op_head),
    .op_pop_o    (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign out_red_o   = result[CH_RED];
  assign out_green_o = result[CH_GREEN];
  assign out_blue_o  = result[CH_BLUE];

endmodule

`default_nettype wire

// ===== rtl/btsmp_fifo.sv =====
// ----------------------------------------------------------------------------
// btsmp_fifo
// Small register queue; the writer guarantees space by credit counting.
// ----------------------------------------------------------------------------
`default_nettype none

module btsmp_fifo #(
  parameter int unsigned DEPTH = btsmp_pkg::QUEUE_DEPTH,
  parameter type         item_t = btsmp_pkg::op_t
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t wdata_i,
  output logic  valid_o,
  output item_t rdata_o,
  input  logic  pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t              entry_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign rdata_o = entry_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != CNT_W'(DEPTH))
    else $error("btsmp_fifo: push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("btsmp_fifo: pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("btsmp_fifo: fill count out of range");

endmodule

`default_nettype wire

// ===== rtl/btsmp_front.sv =====
// ----------------------------------------------------------------------------
// btsmp_front
// Accepts items, holds the size registers, scales and clamps coordinates and
// forms the four texel addresses of a sample before queueing the item.
// ----------------------------------------------------------------------------
`default_nettype none

module btsmp_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [btsmp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [btsmp_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic [btsmp_pkg::INDEX_W-1:0]      texel_index_i,
  input  logic [btsmp_pkg::CH_W-1:0]         load_red_i,
  input  logic [btsmp_pkg::CH_W-1:0]         load_green_i,
  input  logic [btsmp_pkg::CH_W-1:0]         load_blue_i,
  input  logic [btsmp_pkg::COORD_W-1:0]      coord_u_i,
  input  logic [btsmp_pkg::COORD_W-1:0]      coord_v_i,
  output logic                               op_push_o,
  output btsmp_pkg::op_t                     op_o,
  input  logic                               op_pop_i
);

  import btsmp_pkg::*;

  localparam int unsigned CREDIT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ASUM_W   = ROW_W + 1;

  typedef struct packed {
    logic [POS_W-1:0]   p0;
    logic [POS_W-1:0]   p1;
    logic [COORD_W-1:0] frac;
  } axis_t;

  function automatic logic [SIDE_W-1:0] eff_side(input logic [CFG_W-1:0] s);
    logic [SIDE_W-1:0] r;
    if (s == '0) begin
      r = SIDE_W'(1);
    end else if (s > CFG_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = s[SIDE_W-1:0];
    end
    return r;
  endfunction

  // integer position, its clamped neighbour and the remaining fraction
  function automatic axis_t axis_split(input logic [SCALED_W-1:0] sx,
                                       input logic [SIDE_W-1:0]   side);
    logic [SIDE_W:0]     ip;
    logic [SIDE_W-1:0]   last;
    logic [SCALED_W-1:0] rem;
    axis_t               r;
    ip     = sx[SCALED_W-1:COORD_FRAC_BITS];
    last   = side - 1'b1;
    r.p0   = (ip > {1'b0, last}) ? last[POS_W-1:0] : ip[POS_W-1:0];
    r.p1   = (r.p0 == last[POS_W-1:0]) ? r.p0 : r.p0 + 1'b1;
    rem    = sx - SCALED_W'({r.p0, {COORD_FRAC_BITS{1'b0}}});
    r.frac = rem[COORD_W-1:0];
    return r;
  endfunction

  logic [SIDE_W-1:0]   wid_q, hgt_q;
  logic [CREDIT_W-1:0] credit_q, credit_d;
  logic                in_accept;

  logic [COORD_W-1:0]  cu, cv;
  logic [SCALED_W-1:0] sx_d, sy_d;
  axis_t               ax, ay;
  logic [ASUM_W-1:0]   sum00, sum01, sum10, sum11;

  logic                a_vld_q, b_vld_q, c_vld_q;
  cmd_e                a_cmd_q, b_cmd_q, c_cmd_q;
  logic [IDX_W-1:0]    a_idx_q, b_idx_q, c_idx_q;
  texel_t              a_texel_q, b_texel_q, c_texel_q;
  logic [SCALED_W-1:0] a_sx_q, a_sy_q;
  logic [POS_W-1:0]    b_x0_q, b_x1_q, b_y0_q, b_y1_q;
  logic [POS_W-1:0]    c_x0_q, c_x1_q;
  logic [COORD_W-1:0]  b_fx_q, b_fy_q, c_fx_q, c_fy_q;
  logic [ROW_W-1:0]    c_row0_q, c_row1_q;

  // size registers keep the effective side length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q <= SIDE_W'(1);
      hgt_q <= SIDE_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TEX_WIDTH:  wid_q <= eff_side(cfg_wdata_i);
        CFG_TEX_HEIGHT: hgt_q <= eff_side(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // credits cover the front stages and the queue entries
  assign in_stall_o = (credit_q == CREDIT_W'(QUEUE_DEPTH));
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    credit_d = credit_q;
    if (in_accept && !op_pop_i) begin
      credit_d = credit_q + 1'b1;
    end else if (!in_accept && op_pop_i) begin
      credit_d = credit_q - 1'b1;
    end
  end

  assign cu   = (coord_u_i > COORD_ONE) ? COORD_ONE : coord_u_i;
  assign cv   = (coord_v_i > COORD_ONE) ? COORD_ONE : coord_v_i;
  assign sx_d = {{SIDE_W{1'b0}}, cu} * {{COORD_W{1'b0}}, wid_q};
  assign sy_d = {{SIDE_W{1'b0}}, cv} * {{COORD_W{1'b0}}, hgt_q};

  assign ax = axis_split(a_sx_q, wid_q);
  assign ay = axis_split(a_sy_q, hgt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      c_vld_q  <= 1'b0;
    end else begin
      credit_q <= credit_d;
      a_vld_q  <= in_accept;
      b_vld_q  <= a_vld_q;
      c_vld_q  <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_cmd_q           <= cmd_e'(cmd_i);
    a_idx_q           <= texel_index_i[IDX_W-1:0];
    a_texel_q[CH_RED]   <= load_red_i;
    a_texel_q[CH_GREEN] <= load_green_i;
    a_texel_q[CH_BLUE]  <= load_blue_i;
    a_sx_q            <= sx_d;
    a_sy_q            <= sy_d;

    b_cmd_q   <= a_cmd_q;
    b_idx_q   <= a_idx_q;
    b_texel_q <= a_texel_q;
    b_x0_q    <= ax.p0;
    b_x1_q    <= ax.p1;
    b_y0_q    <= ay.p0;
    b_y1_q    <= ay.p1;
    b_fx_q    <= ax.frac;
    b_fy_q    <= ay.frac;

    c_cmd_q   <= b_cmd_q;
    c_idx_q   <= b_idx_q;
    c_texel_q <= b_texel_q;
    c_x0_q    <= b_x0_q;
    c_x1_q    <= b_x1_q;
    c_fx_q    <= b_fx_q;
    c_fy_q    <= b_fy_q;
    c_row0_q  <= {{SIDE_W{1'b0}}, b_y0_q} * {{POS_W{1'b0}}, wid_q};
    c_row1_q  <= {{SIDE_W{1'b0}}, b_y1_q} * {{POS_W{1'b0}}, wid_q};
  end

  // row base plus column, wrapped to the store size
  assign sum00 = {1'b0, c_row0_q} + ASUM_W'(c_x0_q);
  assign sum01 = {1'b0, c_row0_q} + ASUM_W'(c_x1_q);
  assign sum10 = {1'b0, c_row1_q} + ASUM_W'(c_x0_q);
  assign sum11 = {1'b0, c_row1_q} + ASUM_W'(c_x1_q);

  always_comb begin
    op_o.cmd    = c_cmd_q;
    op_o.addr00 = (c_cmd_q == CMD_LOAD) ? c_idx_q : sum00[IDX_W-1:0];
    op_o.addr01 = sum01[IDX_W-1:0];
    op_o.addr10 = sum10[IDX_W-1:0];
    op_o.addr11 = sum11[IDX_W-1:0];
    op_o.texel  = c_texel_q;
    op_o.fx     = c_fx_q;
    op_o.fy     = c_fy_q;
  end

  assign op_push_o = c_vld_q;

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= CREDIT_W'(QUEUE_DEPTH))
    else $error("btsmp_front: credit count out of range");

  a_stages_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CREDIT_W'(a_vld_q) + CREDIT_W'(b_vld_q) + CREDIT_W'(c_vld_q) <= credit_q)
    else $error("btsmp_front: item in flight without credit");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_accept))
    else $error("btsmp_front: stall rose without an accepted item");

endmodule

`default_nettype wire

// ===== rtl/btsmp_back.sv =====
// ----------------------------------------------------------------------------
// btsmp_back
// Texel store in two copies (upper and lower row), each read at two
// addresses, followed by the blend pipeline and the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module btsmp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               op_valid_i,
  input  btsmp_pkg::op_t     op_i,
  output logic               op_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output btsmp_pkg::result_t result_o
);

  import btsmp_pkg::*;

  localparam int unsigned OCREDIT_W = $clog2(OBUF_DEPTH + 1);
  localparam int unsigned MUL1_W    = COORD_W + CH_W;
  localparam int unsigned MUL2_W    = COORD_W + LEFT_W;

  texel_t mem_top [MAX_TEXELS];
  texel_t mem_bot [MAX_TEXELS];

  logic [OCREDIT_W-1:0] ocredit_q, ocredit_d;
  logic                 sample_pop, out_accept;

  texel_t               rd00_q, rd01_q, rd10_q, rd11_q;
  logic                 m_vld_q, p1_vld_q, p2_vld_q;
  logic [COORD_W-1:0]   m_fx_q, m_fy_q, p1_fx_q;
  logic [COORD_W-1:0]   wy0, wx0;

  logic [NUM_CH-1:0][LEFT_W-1:0] left_d, right_d, p1_left_q, p1_right_q;
  logic [NUM_CH-1:0][PROD_W-1:0] pa_d, pb_d, p2_a_q, p2_b_q;
  result_t                       res_d;

  // a sample leaves the queue only when its result has a buffer slot
  assign op_pop_o   = op_valid_i &&
                      (op_i.cmd == CMD_LOAD || ocredit_q != OCREDIT_W'(OBUF_DEPTH));
  assign sample_pop = op_pop_o && (op_i.cmd == CMD_SAMPLE);

  always_ff @(posedge clk_i) begin
    if (op_pop_o && op_i.cmd == CMD_LOAD) begin
      mem_top[op_i.addr00] <= op_i.texel;
      mem_bot[op_i.addr00] <= op_i.texel;
    end
    if (sample_pop) begin
      rd00_q <= mem_top[op_i.addr00];
      rd01_q <= mem_top[op_i.addr01];
      rd10_q <= mem_bot[op_i.addr10];
      rd11_q <= mem_bot[op_i.addr11];
    end
  end

  assign wy0 = COORD_ONE - m_fy_q;
  assign wx0 = COORD_ONE - p1_fx_q;

  always_comb begin
    logic [MUL1_W-1:0] l_full, r_full;
    logic [MUL2_W-1:0] a_full, b_full;
    logic [PROD_W-1:0] s;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      // vertical blend of the left and right columns
      l_full = {{CH_W{1'b0}}, wy0} * {{COORD_W{1'b0}}, rd00_q[ch]}
             + {{CH_W{1'b0}}, m_fy_q} * {{COORD_W{1'b0}}, rd10_q[ch]};
      r_full = {{CH_W{1'b0}}, wy0} * {{COORD_W{1'b0}}, rd01_q[ch]}
             + {{CH_W{1'b0}}, m_fy_q} * {{COORD_W{1'b0}}, rd11_q[ch]};
      left_d[ch]  = l_full[LEFT_W-1:0];
      right_d[ch] = r_full[LEFT_W-1:0];
      // horizontal weights
      a_full   = {{LEFT_W{1'b0}}, wx0} * {{COORD_W{1'b0}}, p1_left_q[ch]};
      b_full   = {{LEFT_W{1'b0}}, p1_fx_q} * {{COORD_W{1'b0}}, p1_right_q[ch]};
      pa_d[ch] = a_full[PROD_W-1:0];
      pb_d[ch] = b_full[PROD_W-1:0];
      s          = p2_a_q[ch] + p2_b_q[ch];
      res_d[ch]  = s[OUT_SHIFT +: OUT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    m_fx_q     <= op_i.fx;
    m_fy_q     <= op_i.fy;
    p1_fx_q    <= m_fx_q;
    p1_left_q  <= left_d;
    p1_right_q <= right_d;
    p2_a_q     <= pa_d;
    p2_b_q     <= pb_d;
  end

  assign out_accept = out_valid_o && !out_stall_i;

  always_comb begin
    ocredit_d = ocredit_q;
    if (sample_pop && !out_accept) begin
      ocredit_d = ocredit_q + 1'b1;
    end else if (!sample_pop && out_accept) begin
      ocredit_d = ocredit_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocredit_q <= '0;
      m_vld_q   <= 1'b0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
    end else begin
      ocredit_q <= ocredit_d;
      m_vld_q   <= sample_pop;
      p1_vld_q  <= m_vld_q;
      p2_vld_q  <= p1_vld_q;
    end
  end

  btsmp_fifo #(
    .DEPTH  (OBUF_DEPTH),
    .item_t (result_t)
  ) u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (p2_vld_q),
    .wdata_i (res_d),
    .valid_o (out_valid_o),
    .rdata_o (result_o),
    .pop_i   (out_accept)
  );

  a_ocredit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocredit_q <= OCREDIT_W'(OBUF_DEPTH))
    else $error("btsmp_back: result credit out of range");

  a_blend_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    OCREDIT_W'(m_vld_q) + OCREDIT_W'(p1_vld_q) + OCREDIT_W'(p2_vld_q) <= ocredit_q)
    else $error("btsmp_back: sample in flight without a buffer slot");

  a_out_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ocredit_q != '0)
    else $error("btsmp_back: result shown without credit");

endmodule

`default_nettype wire
